FILE: design/controller_input_capture_qualifier_core_assert.svh
// Assertion macros shared by the capture qualifier RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef CONTROLLER_INPUT_CAPTURE_QUALIFIER_CORE_ASSERT_SVH
`define CONTROLLER_INPUT_CAPTURE_QUALIFIER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define CICQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capture qualifier check failed");

// Consequent must hold in the cycle after the antecedent.
`define CICQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capture qualifier check failed");

`else

`define CICQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CICQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/cicq_pkg.sv
// Shared types and constants for the controller input capture qualifier.
// No dependencies; used by the rest store and the top level.
package cicq_pkg;

  // Default element counts.
  localparam int MAX_BUTTONS_DEF = 32;
  localparam int MAX_HATS_DEF    = 4;
  localparam int MAX_AXES_DEF    = 8;

  // Opcodes of an input word.
  localparam logic OP_BASELINE = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  // Element kinds.
  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_HAT    = 2'd1;
  localparam logic [1:0] KIND_AXIS   = 2'd2;

  // Configuration register indexes.
  localparam int          CFG_IDX_W     = 1;
  localparam int          CFG_DATA_W    = 16;
  localparam logic [0:0]  CFG_STABILITY = 1'd0;
  localparam logic [0:0]  CFG_THRESHOLD = 1'd1;

  // Register reset values.
  localparam logic [7:0]  STABILITY_RST = 8'd1;
  localparam logic [15:0] THRESHOLD_RST = 16'd16384;

  // A rest magnitude of 0.7 in Q1.15 marks an axis that rests at an extreme.
  localparam logic signed [15:0] EXTREME_REST = 16'sd22938;

  // Detection record; equality covers every field.
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [4:0] idx;
    logic [3:0] mask;
    logic       neg;
    logic       ext;
  } rec_t;

  // Registered read of the rest store.
  typedef struct packed {
    logic               hit;
    logic               btn;
    logic [3:0]         hat;
    logic signed [15:0] axis;
  } rest_rd_t;

  // Best candidates found so far in the current frame.
  typedef struct packed {
    logic        btn_vld;
    logic [4:0]  btn_idx;
    logic        hat_vld;
    logic [4:0]  hat_idx;
    logic [3:0]  hat_new;
    logic        ax_vld;
    logic [4:0]  ax_idx;
    logic [15:0] ax_travel;
    logic        ax_neg;
    logic        ax_ext;
  } frame_best_t;

endpackage

FILE: design/cicq_rest_store.sv
// Rest value store: button, hat and axis memories with per-entry valid bits.
// Depends on cicq_pkg. Read data is registered.
module cicq_rest_store #(
  parameter int MAX_BUTTONS = cicq_pkg::MAX_BUTTONS_DEF,
  parameter int MAX_HATS    = cicq_pkg::MAX_HATS_DEF,
  parameter int MAX_AXES    = cicq_pkg::MAX_AXES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic               rd_en,
  input  logic [1:0]         kind,
  input  logic [4:0]         idx,
  input  logic               wr_btn,
  input  logic [3:0]         wr_hat,
  input  logic signed [15:0] wr_axis,
  output cicq_pkg::rest_rd_t rd_r
);
  import cicq_pkg::*;

  localparam int BAW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int HAW = (MAX_HATS > 1) ? $clog2(MAX_HATS) : 1;
  localparam int AAW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  logic               btn_mem [MAX_BUTTONS];
  logic [3:0]         hat_mem [MAX_HATS];
  logic signed [15:0] axis_mem [MAX_AXES];

  logic [MAX_BUTTONS-1:0] btn_vld_r;
  logic [MAX_HATS-1:0]    hat_vld_r;
  logic [MAX_AXES-1:0]    axis_vld_r;

  logic           b_ok, h_ok, a_ok;
  logic           b_sel, h_sel, a_sel;
  logic [BAW-1:0] b_addr;
  logic [HAW-1:0] h_addr;
  logic [AAW-1:0] a_addr;

  // Index range checks and addresses.
  assign b_ok   = {1'b0, idx} < 6'(MAX_BUTTONS);
  assign h_ok   = {1'b0, idx} < 6'(MAX_HATS);
  assign a_ok   = {1'b0, idx} < 6'(MAX_AXES);
  assign b_sel  = (kind == KIND_BUTTON) && b_ok;
  assign h_sel  = (kind == KIND_HAT) && h_ok;
  assign a_sel  = (kind == KIND_AXIS) && a_ok;
  assign b_addr = idx[BAW-1:0];
  assign h_addr = idx[HAW-1:0];
  assign a_addr = idx[AAW-1:0];

  // Memory writes for baseline words.
  always_ff @(posedge clk) begin
    if (wr_en && b_sel) begin
      btn_mem[b_addr] <= wr_btn;
    end
    if (wr_en && h_sel) begin
      hat_mem[h_addr] <= wr_hat;
    end
    if (wr_en && a_sel) begin
      axis_mem[a_addr] <= wr_axis;
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_vld_r  <= '0;
      hat_vld_r  <= '0;
      axis_vld_r <= '0;
    end else if (wr_en) begin
      if (b_sel) begin
        btn_vld_r[b_addr] <= 1'b1;
      end
      if (h_sel) begin
        hat_vld_r[h_addr] <= 1'b1;
      end
      if (a_sel) begin
        axis_vld_r[a_addr] <= 1'b1;
      end
    end
  end

  // Registered read of all three memories at the word's index.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.hit  <= b_sel || h_sel || a_sel;
      rd_r.btn  <= (b_ok && btn_vld_r[b_addr]) ? btn_mem[b_addr] : 1'b0;
      rd_r.hat  <= (h_ok && hat_vld_r[h_addr]) ? hat_mem[h_addr] : 4'd0;
      rd_r.axis <= (a_ok && axis_vld_r[a_addr]) ? axis_mem[a_addr] : 16'sd0;
    end
  end

endmodule

FILE: design/controller_input_capture_qualifier_core.sv
// Controller input capture qualifier, top level. Depends on cicq_pkg and cicq_rest_store.
// Throughput: one word per cycle while evaluation is not stalled. A word reads the rest
// store on acceptance and is evaluated in the next cycle unless stalled; a report is written
// into the output register as evaluation ends. A full, unread output register stalls evaluation.
// Reset (synchronous, active low) clears the rest store valid bits, frame state,
// tracking records and registers; no clearing pass is needed.
module controller_input_capture_qualifier_core #(
  parameter int MAX_BUTTONS = cicq_pkg::MAX_BUTTONS_DEF,
  parameter int MAX_HATS    = cicq_pkg::MAX_HATS_DEF,
  parameter int MAX_AXES    = cicq_pkg::MAX_AXES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [cicq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cicq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [1:0]                      in_element_kind,
  input  logic [4:0]                      in_element_index,
  input  logic                            in_button_pressed,
  input  logic [3:0]                      in_hat_bits,
  input  logic signed [15:0]              in_axis_sample,
  input  logic                            in_frame_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_detected,
  output logic [1:0]                      out_found_kind,
  output logic [4:0]                      out_found_index,
  output logic [3:0]                      out_found_hat_mask,
  output logic                            out_found_negative,
  output logic                            out_found_at_extreme
);
  import cicq_pkg::*;

  `include "controller_input_capture_qualifier_core_assert.svh"

  // Configuration registers.
  logic [7:0]  stability_r;
  logic [15:0] threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stability_r <= STABILITY_RST;
      threshold_r <= THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_STABILITY: stability_r <= cfg_wdata[7:0];
        CFG_THRESHOLD: threshold_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_vld_r, s1_vld_nxt;
  logic out_valid_r, out_valid_nxt;
  logic stall, s1_go, in_fire;

  assign stall    = out_valid_r && !out_ready;
  assign s1_go    = s1_vld_r && !stall;
  assign in_ready = !s1_vld_r || !stall;
  assign in_fire  = in_valid && in_ready;

  // Rest store, read on every accepted word and written by baseline words.
  rest_rd_t rest_rd;

  cicq_rest_store #(
    .MAX_BUTTONS(MAX_BUTTONS),
    .MAX_HATS   (MAX_HATS),
    .MAX_AXES   (MAX_AXES)
  ) u_rest (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_fire && (in_opcode == OP_BASELINE)),
    .rd_en  (in_fire),
    .kind   (in_element_kind),
    .idx    (in_element_index),
    .wr_btn (in_button_pressed),
    .wr_hat (in_hat_bits),
    .wr_axis(in_axis_sample),
    .rd_r   (rest_rd)
  );

  // Word held for evaluation alongside the rest read.
  logic               s1_op_r;
  logic [1:0]         s1_kind_r;
  logic [4:0]         s1_idx_r;
  logic               s1_btn_r;
  logic [3:0]         s1_hat_r;
  logic signed [15:0] s1_axis_r;
  logic               s1_last_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_opcode;
      s1_kind_r <= in_element_kind;
      s1_idx_r  <= in_element_index;
      s1_btn_r  <= in_button_pressed;
      s1_hat_r  <= in_hat_bits;
      s1_axis_r <= in_axis_sample;
      s1_last_r <= in_frame_last;
    end
  end

  // Frame and tracking state.
  frame_best_t fb_r, fb_nxt, fb_upd;
  rec_t        pend_r, pend_nxt;
  rec_t        latch_r, latch_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  rec_t        out_rec_r, out_rec_nxt;

  // Axis travel against the rest value, computed at 17 bits.
  logic signed [16:0] travel;
  logic [16:0]        travel_abs;
  logic [15:0]        mag;
  logic               ax_neg, ax_ext, ax_better;
  logic [3:0]         hat_added;

  assign travel     = {s1_axis_r[15], s1_axis_r} - {rest_rd.axis[15], rest_rd.axis};
  assign ax_neg     = travel[16];
  assign travel_abs = ax_neg ? 17'(-travel) : 17'(travel);
  assign mag        = travel_abs[15:0];
  assign ax_ext     = (rest_rd.axis >= EXTREME_REST) || (rest_rd.axis <= -EXTREME_REST);
  assign ax_better  = (mag > threshold_r) &&
                      (!fb_r.ax_vld || (mag > fb_r.ax_travel) ||
                       ((mag == fb_r.ax_travel) && (s1_idx_r < fb_r.ax_idx)));
  assign hat_added  = s1_hat_r & ~rest_rd.hat;

  // Sample evaluation against the frame's best candidates.
  always_comb begin
    fb_upd = fb_r;
    if (rest_rd.hit) begin
      case (s1_kind_r)
        KIND_BUTTON: begin
          if (s1_btn_r && !rest_rd.btn && (!fb_r.btn_vld || (s1_idx_r < fb_r.btn_idx))) begin
            fb_upd.btn_vld = 1'b1;
            fb_upd.btn_idx = s1_idx_r;
          end
        end
        KIND_HAT: begin
          if ((hat_added != 4'd0) && (!fb_r.hat_vld || (s1_idx_r < fb_r.hat_idx))) begin
            fb_upd.hat_vld = 1'b1;
            fb_upd.hat_idx = s1_idx_r;
            fb_upd.hat_new = hat_added;
          end
        end
        KIND_AXIS: begin
          if (ax_better) begin
            fb_upd.ax_vld    = 1'b1;
            fb_upd.ax_idx    = s1_idx_r;
            fb_upd.ax_travel = mag;
            fb_upd.ax_neg    = ax_neg;
            fb_upd.ax_ext    = ax_ext;
          end
        end
        default: ;
      endcase
    end
  end

  // Frame result in priority order: button, then hat, then axis.
  rec_t       found;
  logic [7:0] need, cnt_step;
  logic       report;

  always_comb begin
    found = '0;
    if (fb_upd.btn_vld) begin
      found.vld  = 1'b1;
      found.kind = KIND_BUTTON;
      found.idx  = fb_upd.btn_idx;
    end else if (fb_upd.hat_vld) begin
      found.vld  = 1'b1;
      found.kind = KIND_HAT;
      found.idx  = fb_upd.hat_idx;
      found.mask = fb_upd.hat_new;
    end else if (fb_upd.ax_vld) begin
      found.vld  = 1'b1;
      found.kind = KIND_AXIS;
      found.idx  = fb_upd.ax_idx;
      found.neg  = fb_upd.ax_neg;
      found.ext  = fb_upd.ax_ext;
    end
  end

  assign need = (stability_r == 8'd0) ? 8'd1 : stability_r;

  // Frame end handling, stability counting and reporting.
  always_comb begin
    fb_nxt      = fb_r;
    pend_nxt    = pend_r;
    latch_nxt   = latch_r;
    cnt_nxt     = cnt_r;
    out_rec_nxt = out_rec_r;
    report      = 1'b0;
    cnt_step    = cnt_r;
    if (s1_go) begin
      if (s1_op_r == OP_BASELINE) begin
        fb_nxt    = '0;
        pend_nxt  = '0;
        latch_nxt = '0;
        cnt_nxt   = 8'd0;
      end else if (!s1_last_r) begin
        fb_nxt = fb_upd;
      end else begin
        fb_nxt = '0;
        if (!found.vld) begin
          pend_nxt  = '0;
          latch_nxt = '0;
          cnt_nxt   = 8'd0;
        end else if (found != latch_r) begin
          if (found == pend_r) begin
            cnt_step = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
          end else begin
            pend_nxt = found;
            cnt_step = 8'd1;
          end
          cnt_nxt = cnt_step;
          if (cnt_step >= need) begin
            report      = 1'b1;
            latch_nxt   = found;
            pend_nxt    = '0;
            cnt_nxt     = 8'd0;
            out_rec_nxt = found;
          end
        end
      end
    end
  end

  assign s1_vld_nxt    = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_vld_r);
  assign out_valid_nxt = report ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control and tracking registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fb_r        <= '0;
      pend_r      <= '0;
      latch_r     <= '0;
      cnt_r       <= 8'd0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      fb_r        <= fb_nxt;
      pend_r      <= pend_nxt;
      latch_r     <= latch_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_detected         = out_rec_r.vld;
  assign out_found_kind       = out_rec_r.kind;
  assign out_found_index      = out_rec_r.idx;
  assign out_found_hat_mask   = out_rec_r.mask;
  assign out_found_negative   = out_rec_r.neg;
  assign out_found_at_extreme = out_rec_r.ext;

  // A report leaves a valid latched record and a waiting output word.
  `CICQ_ASSERT_NEXT(a_report_latches, clk, rst_n, s1_go && report, latch_r.vld && out_valid_r)
  // A pending candidate never equals the latched record.
  `CICQ_ASSERT_NOW(a_pend_not_latched, clk, rst_n, pend_r.vld, pend_r != latch_r)
  // The repeat count is nonzero exactly while a candidate is pending.
  `CICQ_ASSERT_NOW(a_cnt_tracks_pend, clk, rst_n, 1'b1, (cnt_r != 8'd0) == pend_r.vld)

endmodule

FILE: tb/sv/controller_input_capture_qualifier_core_test.sv
// Self-checking testbench for controller_input_capture_qualifier_core.
// Holds a scoreboard class that predicts reports from accepted words, plus the
// tasks that drive the block. Depends on cicq_pkg and the block's RTL.
module controller_input_capture_qualifier_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cicq_pkg::*;

  localparam int MAX_BTN      = MAX_BUTTONS_DEF;
  localparam int MAX_HAT      = MAX_HATS_DEF;
  localparam int MAX_AX       = MAX_AXES_DEF;
  localparam int EXTREME_INT  = 22938;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_SHOWN    = 10;

  // Element kind with no meaning; the block ignores it.
  localparam logic [1:0] KIND_NONE = 2'd3;

  // One input word as the sender presents it.
  typedef struct packed {
    logic               op;
    logic [1:0]         kind;
    logic [4:0]         idx;
    logic               btn;
    logic [3:0]         hat;
    logic signed [15:0] axis;
    logic               last;
  } word_t;

  // Predicts detection reports from accepted words and checks the reports seen.
  class detect_scoreboard;
    logic [7:0]         stability;
    logic [15:0]        threshold;
    logic               rest_btn  [MAX_BTN];
    logic [3:0]         rest_hat  [MAX_HAT];
    logic signed [15:0] rest_axis [MAX_AX];
    frame_best_t        best;
    rec_t               pending;
    rec_t               latched;
    logic [7:0]         repeat_cnt;
    rec_t               expected_reports[$];
    int                 mismatches;
    int                 reports_checked;

    function new();
      stability = STABILITY_RST;
      threshold = THRESHOLD_RST;
      foreach (rest_btn[i]) rest_btn[i] = 1'b0;
      foreach (rest_hat[i]) rest_hat[i] = 4'd0;
      foreach (rest_axis[i]) rest_axis[i] = 16'sd0;
      best = '0;
      pending = '0;
      latched = '0;
      repeat_cnt = 8'd0;
      mismatches = 0;
      reports_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_STABILITY) stability = data[7:0];
      else if (index == CFG_THRESHOLD) threshold = data;
    endfunction

    // Updates the predicted state for one accepted word.
    function void note_word(word_t w);
      int         s;
      int         r;
      int         t;
      int         mag;
      int         thr;
      logic [3:0] added;
      rec_t       found;
      logic [7:0] need;

      // A baseline word stores a rest value and restarts all tracking.
      if (w.op == OP_BASELINE) begin
        if (w.kind == KIND_BUTTON && int'(w.idx) < MAX_BTN) rest_btn[w.idx] = w.btn;
        else if (w.kind == KIND_HAT && int'(w.idx) < MAX_HAT) rest_hat[w.idx] = w.hat;
        else if (w.kind == KIND_AXIS && int'(w.idx) < MAX_AX) rest_axis[w.idx] = w.axis;
        pending = '0;
        latched = '0;
        repeat_cnt = 8'd0;
        best = '0;
        return;
      end

      // Fold this element into the best candidates of the frame.
      case (w.kind)
        KIND_BUTTON: begin
          if (int'(w.idx) < MAX_BTN && w.btn && !rest_btn[w.idx] &&
              (!best.btn_vld || w.idx < best.btn_idx)) begin
            best.btn_vld = 1'b1;
            best.btn_idx = w.idx;
          end
        end
        KIND_HAT: begin
          if (int'(w.idx) < MAX_HAT) begin
            added = w.hat & ~rest_hat[w.idx];
            if (added != 4'd0 && (!best.hat_vld || w.idx < best.hat_idx)) begin
              best.hat_vld = 1'b1;
              best.hat_idx = w.idx;
              best.hat_new = added;
            end
          end
        end
        KIND_AXIS: begin
          if (int'(w.idx) < MAX_AX) begin
            r = $signed(rest_axis[w.idx]);
            s = $signed(w.axis);
            t = s - r;
            mag = (t < 0) ? -t : t;
            thr = threshold;
            if (mag > thr && (!best.ax_vld || mag > int'(best.ax_travel) ||
                (mag == int'(best.ax_travel) && w.idx < best.ax_idx))) begin
              best.ax_vld = 1'b1;
              best.ax_idx = w.idx;
              best.ax_travel = mag[15:0];
              best.ax_neg = (t < 0);
              best.ax_ext = (((r < 0) ? -r : r) >= EXTREME_INT);
            end
          end
        end
        default: ;
      endcase
      if (!w.last) return;

      // Frame end: buttons beat hats, hats beat axes.
      found = '0;
      if (best.btn_vld) begin
        found.vld = 1'b1;
        found.kind = KIND_BUTTON;
        found.idx = best.btn_idx;
      end else if (best.hat_vld) begin
        found.vld = 1'b1;
        found.kind = KIND_HAT;
        found.idx = best.hat_idx;
        found.mask = best.hat_new;
      end else if (best.ax_vld) begin
        found.vld = 1'b1;
        found.kind = KIND_AXIS;
        found.idx = best.ax_idx;
        found.neg = best.ax_neg;
        found.ext = best.ax_ext;
      end
      best = '0;

      if (!found.vld) begin
        pending = '0;
        latched = '0;
        repeat_cnt = 8'd0;
        return;
      end
      if (found == latched) return;
      if (found == pending) begin
        if (repeat_cnt != 8'd255) repeat_cnt = repeat_cnt + 8'd1;
      end else begin
        pending = found;
        repeat_cnt = 8'd1;
      end
      need = (stability == 8'd0) ? 8'd1 : stability;
      if (repeat_cnt < need) return;
      latched = found;
      pending = '0;
      repeat_cnt = 8'd0;
      expected_reports = {expected_reports, found};
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("%s", msg);
    endfunction

    // Compares one accepted report with the oldest expected one.
    function void check_report(logic det, logic [1:0] kind, logic [4:0] idx,
                               logic [3:0] mask, logic neg, logic ext);
      rec_t exp_rec;
      reports_checked++;
      if (expected_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected report: kind %0d index %0d mask %h neg %0d ext %0d",
                                kind, idx, mask, neg, ext));
        return;
      end
      exp_rec = expected_reports.pop_front();
      if (det !== 1'b1 || kind !== exp_rec.kind || idx !== exp_rec.idx ||
          mask !== exp_rec.mask || neg !== exp_rec.neg || ext !== exp_rec.ext) begin
        note_mismatch({
          $sformatf("report mismatch: expected det 1 kind %0d index %0d mask %h neg %0d ext %0d, ",
                    exp_rec.kind, exp_rec.idx, exp_rec.mask, exp_rec.neg, exp_rec.ext),
          $sformatf("got det %0d kind %0d index %0d mask %h neg %0d ext %0d",
                    det, kind, idx, mask, neg, ext)});
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_opcode;
  logic [1:0]            in_element_kind;
  logic [4:0]            in_element_index;
  logic                  in_button_pressed;
  logic [3:0]            in_hat_bits;
  logic signed [15:0]    in_axis_sample;
  logic                  in_frame_last;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_detected;
  logic [1:0]            out_found_kind;
  logic [4:0]            out_found_index;
  logic [3:0]            out_found_hat_mask;
  logic                  out_found_negative;
  logic                  out_found_at_extreme;

  detect_scoreboard sb = new();
  bit no_idle;
  int words_sent;
  int settings_used;
  int cycle_count;

  controller_input_capture_qualifier_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_element_kind      (in_element_kind),
    .in_element_index     (in_element_index),
    .in_button_pressed    (in_button_pressed),
    .in_hat_bits          (in_hat_bits),
    .in_axis_sample       (in_axis_sample),
    .in_frame_last        (in_frame_last),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_detected         (out_detected),
    .out_found_kind       (out_found_kind),
    .out_found_index      (out_found_index),
    .out_found_hat_mask   (out_found_hat_mask),
    .out_found_negative   (out_found_negative),
    .out_found_at_extreme (out_found_at_extreme)
  );

  // Free-running clock with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reports outstanding.",
               cycle_count, sb.expected_reports.size());
      $display("** controller_input_capture_qualifier_core: FAILED **");
      $finish;
    end
  end

  // Idle cycles before the next word on either side.
  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    int c;
    c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    return c[15:0];
  endfunction

  function automatic word_t mk(logic op, logic [1:0] kind, int idx, logic btn,
                               logic [3:0] hat, int axis, logic last);
    word_t w;
    w.op = op;
    w.kind = kind;
    w.idx = idx[4:0];
    w.btn = btn;
    w.hat = hat;
    w.axis = axis[15:0];
    w.last = last;
    return w;
  endfunction

  // A sample word: mostly in-range indexes, axes often full scale, at threshold or near rest.
  function automatic word_t rand_sample_word();
    word_t w;
    int    r;
    int    rest;
    int    delta;
    r = $urandom_range(0, 99);
    w.op = OP_SAMPLE;
    w.kind = (r < 35) ? KIND_BUTTON : ((r < 65) ? KIND_HAT : KIND_AXIS);
    w.btn = ($urandom_range(0, 9) < 7);
    w.hat = 4'($urandom);
    w.axis = 16'($urandom);
    w.last = 1'b0;
    case (w.kind)
      KIND_HAT: w.idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, MAX_HAT - 1));
      KIND_AXIS: w.idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(0, MAX_AX - 1));
      default: w.idx = 5'($urandom_range(0, MAX_BTN - 1));
    endcase
    if (w.kind == KIND_AXIS) begin
      rest = (int'(w.idx) < MAX_AX) ? $signed(sb.rest_axis[w.idx]) : 0;
      case ($urandom_range(0, 3))
        1: w.axis = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        2: begin
          // Travel right at the threshold or one step past it.
          delta = int'(sb.threshold) + int'($urandom_range(0, 1));
          w.axis = clip16($urandom_range(0, 1) ? rest + delta : rest - delta);
        end
        3: w.axis = clip16(rest + int'($urandom_range(0, 200)) - 100);
        default: ;
      endcase
    end
    return w;
  endfunction

  // A baseline word; axis rests often sit at the extreme-rest boundary.
  function automatic word_t rand_baseline_word();
    word_t w;
    int    r;
    r = $urandom_range(0, 99);
    w.op = OP_BASELINE;
    w.kind = (r < 30) ? KIND_BUTTON : ((r < 60) ? KIND_HAT : KIND_AXIS);
    w.idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(0, 7));
    w.btn = 1'($urandom);
    w.hat = 4'($urandom);
    w.last = 1'($urandom);
    case ($urandom_range(0, 5))
      0: w.axis = $urandom_range(0, 1) ? 16'sd22937 : -16'sd22937;
      1: w.axis = $urandom_range(0, 1) ? 16'sd22938 : -16'sd22938;
      2: w.axis = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3: w.axis = 16'sd0;
      default: w.axis = 16'($urandom);
    endcase
    return w;
  endfunction

  // Presents one word and waits for it to be accepted.
  task automatic send_word(word_t w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_opcode = w.op;
    in_element_kind = w.kind;
    in_element_index = w.idx;
    in_button_pressed = w.btn;
    in_hat_bits = w.hat;
    in_axis_sample = w.axis;
    in_frame_last = w.last;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  // Holds off the sender until every expected report has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_phase(logic [7:0] stab, logic [15:0] thr);
    drain();
    cfg_write(CFG_STABILITY, {8'd0, stab});
    cfg_write(CFG_THRESHOLD, thr);
    no_idle = ($urandom_range(0, 3) == 0);
    settings_used++;
  endtask

  // Short hand-picked sequence run at the reset settings.
  task automatic run_directed();
    send_word(mk(OP_BASELINE, KIND_BUTTON, 5, 1'b1, 4'h0, 0, 1'b0));
    send_word(mk(OP_BASELINE, KIND_HAT, 2, 1'b0, 4'h3, 0, 1'b0));
    send_word(mk(OP_BASELINE, KIND_AXIS, 3, 1'b0, 4'h0, -32768, 1'b0));
    send_word(mk(OP_BASELINE, KIND_AXIS, 7, 1'b0, 4'h0, 32767, 1'b0));
    // Baseline with an unused kind and the frame mark set still reports nothing.
    send_word(mk(OP_BASELINE, KIND_NONE, 31, 1'b1, 4'hf, -1, 1'b1));
    // A button that rests pressed is not new.
    send_word(mk(OP_SAMPLE, KIND_BUTTON, 5, 1'b1, 4'h0, 0, 1'b1));
    // The lowest new button wins; repeating it stays latched.
    send_word(mk(OP_SAMPLE, KIND_BUTTON, 31, 1'b1, 4'h0, 0, 1'b0));
    send_word(mk(OP_SAMPLE, KIND_BUTTON, 0, 1'b1, 4'h0, 0, 1'b1));
    send_word(mk(OP_SAMPLE, KIND_BUTTON, 0, 1'b1, 4'h0, 0, 1'b1));
    // Hat reports only the bits clear at rest; rest bits alone clear the latch.
    send_word(mk(OP_SAMPLE, KIND_HAT, 2, 1'b0, 4'hf, 0, 1'b1));
    send_word(mk(OP_SAMPLE, KIND_HAT, 2, 1'b0, 4'h3, 0, 1'b1));
    // Full-scale axis travel in both directions from extreme rests.
    send_word(mk(OP_SAMPLE, KIND_AXIS, 3, 1'b0, 4'h0, 32767, 1'b1));
    send_word(mk(OP_SAMPLE, KIND_AXIS, 7, 1'b0, 4'h0, -32768, 1'b0));
    send_word(mk(OP_SAMPLE, KIND_AXIS, 3, 1'b0, 4'h0, -32768, 1'b1));
    // Equal travel goes to the lower axis.
    send_word(mk(OP_SAMPLE, KIND_AXIS, 0, 1'b0, 4'h0, 20000, 1'b0));
    send_word(mk(OP_SAMPLE, KIND_AXIS, 1, 1'b0, 4'h0, 20000, 1'b1));
    // Travel equal to the threshold is not enough, one more is.
    send_word(mk(OP_SAMPLE, KIND_AXIS, 0, 1'b0, 4'h0, 16384, 1'b1));
    send_word(mk(OP_SAMPLE, KIND_AXIS, 0, 1'b0, 4'h0, 16385, 1'b1));
    // Out-of-range indexes and the unused kind are ignored.
    send_word(mk(OP_SAMPLE, KIND_HAT, 9, 1'b0, 4'hf, 0, 1'b0));
    send_word(mk(OP_SAMPLE, KIND_AXIS, 20, 1'b0, 4'h0, 32767, 1'b0));
    send_word(mk(OP_SAMPLE, KIND_NONE, 0, 1'b1, 4'hf, 32767, 1'b1));
    // Priority: button over hat over axis.
    send_word(mk(OP_SAMPLE, KIND_AXIS, 0, 1'b0, 4'h0, -20000, 1'b0));
    send_word(mk(OP_SAMPLE, KIND_HAT, 0, 1'b0, 4'h1, 0, 1'b0));
    send_word(mk(OP_SAMPLE, KIND_BUTTON, 3, 1'b1, 4'h0, 0, 1'b1));
    send_word(mk(OP_SAMPLE, KIND_HAT, 0, 1'b0, 4'h1, 0, 1'b0));
    send_word(mk(OP_SAMPLE, KIND_AXIS, 0, 1'b0, 4'h0, -20000, 1'b1));
    // A baseline word in mid-frame discards the partial frame.
    send_word(mk(OP_SAMPLE, KIND_BUTTON, 4, 1'b1, 4'h0, 0, 1'b0));
    send_word(mk(OP_BASELINE, KIND_BUTTON, 4, 1'b0, 4'h0, 0, 1'b1));
    send_word(mk(OP_SAMPLE, KIND_HAT, 1, 1'b0, 4'h8, 0, 1'b1));
  endtask

  // Mostly repeated well-formed frames, with rest frames, baselines and noise.
  task automatic run_random(int count);
    word_t       tmpl[5];
    word_t       w;
    logic [31:0] raw;
    int          start;
    int          len;
    int          reps;
    int          cap;
    int          need;
    int          r;
    int          j;
    start = words_sent;
    while (words_sent - start < count) begin
      if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_word(rand_baseline_word());
      end else if (r < 13) begin
        // Raw noise: any opcode, kind, index and frame mark.
        repeat ($urandom_range(1, 3)) begin
          raw = $urandom;
          w = raw[$bits(word_t)-1:0];
          w.axis = 16'($urandom);
          send_word(w);
        end
      end else if (r < 22) begin
        // A frame of elements at rest releases the latch.
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          w = rand_sample_word();
          if (int'(w.idx) < MAX_BTN && w.kind == KIND_BUTTON) w.btn = sb.rest_btn[w.idx];
          if (int'(w.idx) < MAX_HAT && w.kind == KIND_HAT) w.hat = w.hat & sb.rest_hat[w.idx];
          if (int'(w.idx) < MAX_AX && w.kind == KIND_AXIS) w.axis = sb.rest_axis[w.idx];
          w.last = (i == len - 1);
          send_word(w);
        end
      end else begin
        // One frame repeated enough times to reach or just miss the report.
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          tmpl[i] = rand_sample_word();
          tmpl[i].last = (i == len - 1);
        end
        need = (sb.stability == 8'd0) ? 1 : int'(sb.stability);
        cap = (need + 1 > 6) ? 6 : need + 1;
        reps = $urandom_range(1, cap);
        for (int k = 0; k < reps; k++) begin
          if (k > 0 && $urandom_range(0, 99) < 15) begin
            j = $urandom_range(0, len - 1);
            tmpl[j] = rand_sample_word();
            tmpl[j].last = (j == len - 1);
          end
          for (int i = 0; i < len; i++) send_word(tmpl[i]);
        end
      end
    end
  endtask

  // Result side: random stalls between reports, each report checked on acceptance.
  initial begin : result_side
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
      sb.check_report(out_detected, out_found_kind, out_found_index, out_found_hat_mask,
                      out_found_negative, out_found_at_extreme);
    end
  end

  // Main sequence: reset, directed words, then random phases over several settings.
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_STABILITY;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_opcode = OP_SAMPLE;
    in_element_kind = KIND_BUTTON;
    in_element_index = 5'd0;
    in_button_pressed = 1'b0;
    in_hat_bits = 4'd0;
    in_axis_sample = 16'sd0;
    in_frame_last = 1'b0;
    no_idle = 1'b0;
    words_sent = 0;
    settings_used = 1;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    set_phase(8'd1, 16'd16384);
    run_random(250);
    set_phase(8'd0, 16'd0);
    run_random(200);
    set_phase(8'd2, 16'hffff);
    run_random(150);
    set_phase(8'd3, 16'($urandom));
    run_random(200);

    // Deepest stability: one frame repeated past the required count.
    set_phase(8'd255, 16'd1000);
    send_word(mk(OP_BASELINE, KIND_BUTTON, 2, 1'b0, 4'h0, 0, 1'b0));
    repeat (256) send_word(mk(OP_SAMPLE, KIND_BUTTON, 2, 1'b1, 4'h0, 0, 1'b1));

    set_phase(8'($urandom_range(1, 4)), 16'($urandom));
    run_random(300);
    set_phase(8'd1, 16'($urandom_range(0, 40000)));
    run_random(250);
    drain();

    $display("Covered %0d input words under %0d register settings; %0d reports checked.",
             words_sent, settings_used, sb.reports_checked);
    $display("Mismatches: %0d, reports still expected: %0d.",
             sb.mismatches, sb.expected_reports.size());
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("** controller_input_capture_qualifier_core: PASSED **");
    end else begin
      $display("** controller_input_capture_qualifier_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/cicq_pkg.sv
design/cicq_rest_store.sv
design/controller_input_capture_qualifier_core.sv
tb/sv/controller_input_capture_qualifier_core_test.sv
